FILE: sv/vertex_cache_miss_counter_core_macros.svh
// assertion macros for the vertex cache miss counter core
// expects aclk and aresetn in the scope of each use
`ifndef VERTEX_CACHE_MISS_COUNTER_CORE_MACROS_SVH
`define VERTEX_CACHE_MISS_COUNTER_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define VCMC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define VCMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/vcmc_pkg.sv
// shared types and constants for the vertex cache miss counter core
// no dependencies
package vcmc_pkg;

    localparam int CACHE_DEPTH_DEF = 8;
    localparam int INDEX_BITS_DEF  = 16;
    localparam int VERTEX_W        = 16;
    localparam int COUNT_W         = 2;
    localparam int TOTAL_W         = 32;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex_a;
        logic [VERTEX_W-1:0] vertex_b;
        logic [VERTEX_W-1:0] vertex_c;
        logic                restart;
        logic                last_triangle;
    } tri_in_t;

    typedef struct packed {
        logic [COUNT_W-1:0] hit_count;
        logic [COUNT_W-1:0] miss_count;
        logic [TOTAL_W-1:0] miss_total;
        logic               is_last;
    } tri_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY_A,
        ST_APPLY_B,
        ST_APPLY_C
    } state_t;

    typedef enum logic [1:0] {
        SEL_A,
        SEL_B,
        SEL_C
    } vsel_t;

    typedef struct packed {
        logic  capture;
        logic  count_hits;
        logic  apply;
        vsel_t sel;
        logic  publish;
    } cmd_t;

endpackage

FILE: sv/vertex_cache_miss_counter_core.sv
// top level of the vertex cache miss counter: controller, datapath, checks
// depends on vcmc_pkg, vcmc_ctrl, vcmc_datapath and the macros header
//
//   port group     dir   role
//   s_valid/ready  in    triangle transfer: three vertex indices, restart, last flag
//   m_valid/ready  out   result transfer: hit/miss counts, miss total, last echo
//
// a triangle passes through the update states A, B and C, one ordered cache update per
// cycle through the single compare-and-swap unit while the result side is free; the
// next triangle can be accepted alongside update C, which also registers the result.
// reset clears the state machine, occupancy and the miss total; cache entries
// hold no reset value and are only read below the occupancy.
// a stalled result holds the third update until the result register frees up.
`include "vertex_cache_miss_counter_core_macros.svh"

module vertex_cache_miss_counter_core
    import vcmc_pkg::*;
#(
    parameter int CACHE_DEPTH = CACHE_DEPTH_DEF,
    parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  tri_in_t  s_payload,
    output logic     m_valid,
    input  logic     m_ready,
    output tri_out_t m_payload
);

    localparam int OCC_W = $clog2(CACHE_DEPTH + 1);

    cmd_t             cmd;
    logic [OCC_W-1:0] occupancy;

    // sequencing: accept, three updates, publish
    vcmc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // cache, counters and result register
    vcmc_datapath #(
        .CACHE_DEPTH (CACHE_DEPTH),
        .INDEX_BITS  (INDEX_BITS),
        .OCC_W       (OCC_W)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .m_payload (m_payload),
        .occupancy (occupancy)
    );

    // every index of a triangle is either a hit or a miss
    `VCMC_ASSERT_NOW(a_counts_sum, m_valid, ({1'b0, m_payload.hit_count} + {1'b0, m_payload.miss_count}) == 3'd3, "hit and miss counts do not add to three")
    // the cache never holds more than its depth
    `VCMC_ASSERT_NOW(a_occ_bound, 1'b1, occupancy <= OCC_W'(CACHE_DEPTH), "occupancy above cache depth")
    // a published result is offered in the next cycle
    `VCMC_ASSERT_NEXT(a_publish_valid, cmd.publish, m_valid, "published result not offered")
    // a transfer in starts the first cache update right after
    `VCMC_ASSERT_NEXT(a_accept_apply, s_valid && s_ready, cmd.apply && cmd.count_hits, "accepted triangle not processed")

endmodule

FILE: sv/vcmc_ctrl.sv
// controller state machine: sequences three cache updates per triangle
// depends on vcmc_pkg
module vcmc_ctrl
    import vcmc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   can_publish;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign can_publish = !out_valid_reg || m_ready;
    assign m_valid     = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        s_ready        = 1'b0;
        cmd            = '0;
        cmd.sel        = SEL_A;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_APPLY_A;
                end
            end
            ST_APPLY_A: begin
                cmd.count_hits = 1'b1;
                cmd.apply      = 1'b1;
                cmd.sel        = SEL_A;
                state_next     = ST_APPLY_B;
            end
            ST_APPLY_B: begin
                cmd.apply  = 1'b1;
                cmd.sel    = SEL_B;
                state_next = ST_APPLY_C;
            end
            ST_APPLY_C: begin
                // last update waits until the result register is free
                if (can_publish) begin
                    cmd.apply   = 1'b1;
                    cmd.sel     = SEL_C;
                    cmd.publish = 1'b1;
                    s_ready     = 1'b1;
                    if (s_valid) begin
                        cmd.capture = 1'b1;
                        state_next  = ST_APPLY_A;
                    end else begin
                        state_next  = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = cmd.publish ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

endmodule

FILE: sv/vcmc_datapath.sv
// datapath: triangle registers, ordered cache, compare and update, miss total
// depends on vcmc_pkg
module vcmc_datapath
    import vcmc_pkg::*;
#(
    parameter int CACHE_DEPTH = CACHE_DEPTH_DEF,
    parameter int INDEX_BITS  = INDEX_BITS_DEF,
    parameter int OCC_W       = $clog2(CACHE_DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  tri_in_t          s_payload,
    input  cmd_t             cmd,
    output tri_out_t         m_payload,
    output logic [OCC_W-1:0] occupancy
);

    localparam int IDX_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;

    logic [INDEX_BITS-1:0] entries_reg  [CACHE_DEPTH];
    logic [INDEX_BITS-1:0] entries_next [CACHE_DEPTH];
    logic [INDEX_BITS-1:0] va_reg, vb_reg, vc_reg, vcur;
    logic                  last_reg;
    logic [OCC_W-1:0]      occ_reg, occ_next;
    logic [TOTAL_W-1:0]    sum_reg, sum_next, sum_sat;
    logic [TOTAL_W:0]      sum_wide;
    logic [COUNT_W-1:0]    hits_reg, hits_next, misses;
    tri_out_t              out_reg, out_next;

    logic [CACHE_DEPTH-1:0] match_a, match_b, match_c, match_cur;
    logic [IDX_W-1:0]       slot, newest;
    logic                   cur_hit, full;

    // parallel compare of the valid entries
    always_comb begin
        for (int i = 0; i < CACHE_DEPTH; i++) begin
            match_a[i]   = (OCC_W'(i) < occ_reg) && (entries_reg[i] == va_reg);
            match_b[i]   = (OCC_W'(i) < occ_reg) && (entries_reg[i] == vb_reg);
            match_c[i]   = (OCC_W'(i) < occ_reg) && (entries_reg[i] == vc_reg);
            match_cur[i] = (OCC_W'(i) < occ_reg) && (entries_reg[i] == vcur);
        end
        slot = '0;
        for (int i = CACHE_DEPTH - 1; i >= 0; i--) begin
            if (match_cur[i]) begin
                slot = IDX_W'(i);
            end
        end
    end

    always_comb begin
        case (cmd.sel)
            SEL_A:   vcur = va_reg;
            SEL_B:   vcur = vb_reg;
            SEL_C:   vcur = vc_reg;
            default: vcur = va_reg;
        endcase
    end

    assign cur_hit   = |match_cur;
    assign full      = (occ_reg == OCC_W'(CACHE_DEPTH));
    assign newest    = IDX_W'(occ_reg - OCC_W'(1));
    assign hits_next = cmd.count_hits
                     ? (COUNT_W'(|match_a) + COUNT_W'(|match_b) + COUNT_W'(|match_c))
                     : hits_reg;
    assign misses    = COUNT_W'(3) - hits_reg;

    // one ordered cache update: swap to newest on hit, append or shift on miss
    always_comb begin
        entries_next = entries_reg;
        occ_next     = occ_reg;
        if (cmd.apply) begin
            if (cur_hit) begin
                for (int i = 0; i < CACHE_DEPTH; i++) begin
                    if (IDX_W'(i) == slot) begin
                        entries_next[i] = entries_reg[newest];
                    end else if (IDX_W'(i) == newest) begin
                        entries_next[i] = entries_reg[slot];
                    end
                end
            end else if (!full) begin
                entries_next[occ_reg[IDX_W-1:0]] = vcur;
                occ_next = occ_reg + OCC_W'(1);
            end else begin
                for (int i = 0; i < CACHE_DEPTH - 1; i++) begin
                    entries_next[i] = entries_reg[i + 1];
                end
                entries_next[CACHE_DEPTH - 1] = vcur;
            end
        end
        // restart of the next triangle overrides the update of the current one
        if (cmd.capture && s_payload.restart) begin
            occ_next = '0;
        end
    end

    // saturating miss total
    always_comb begin
        sum_wide = {1'b0, sum_reg} + (TOTAL_W + 1)'(misses);
        sum_sat  = sum_wide[TOTAL_W] ? '1 : sum_wide[TOTAL_W-1:0];
        sum_next = cmd.publish ? sum_sat : sum_reg;
        if (cmd.capture && s_payload.restart) begin
            sum_next = '0;
        end
        out_next = out_reg;
        if (cmd.publish) begin
            out_next.hit_count  = hits_reg;
            out_next.miss_count = misses;
            out_next.miss_total = sum_sat;
            out_next.is_last    = last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
            sum_reg <= '0;
        end else begin
            occ_reg <= occ_next;
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        entries_reg <= entries_next;
        hits_reg    <= hits_next;
        out_reg     <= out_next;
        if (cmd.capture) begin
            va_reg   <= INDEX_BITS'(32'(s_payload.vertex_a));
            vb_reg   <= INDEX_BITS'(32'(s_payload.vertex_b));
            vc_reg   <= INDEX_BITS'(32'(s_payload.vertex_c));
            last_reg <= s_payload.last_triangle;
        end
    end

    assign m_payload = out_reg;
    assign occupancy = occ_reg;

endmodule

FILE: bench/tb.sv
// self-checking testbench for vertex_cache_miss_counter_core
// depends on vcmc_pkg and the core rtl; reads nothing, needs no arguments
`timescale 1ns / 1ps

module tb;
    import vcmc_pkg::*;

    // cycles without any transfer before the run is declared hung; the long
    // receiver hold-off below is the slowest correct stretch by far
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 12;
    localparam int TALLY_SLOTS     = 16;

    logic     aclk;
    logic     aresetn   = 1'b0;
    logic     s_valid   = 1'b0;
    logic     s_ready;
    tri_in_t  s_payload = '0;
    logic     m_valid;
    logic     m_ready   = 1'b0;
    tri_out_t m_payload;

    vertex_cache_miss_counter_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // shadow of the cache: slot 0 is the oldest entry, slot held_entries-1 the newest
    logic [VERTEX_W-1:0] cache_slots [CACHE_DEPTH_DEF];
    int unsigned         held_entries = 0;
    logic [TOTAL_W-1:0]  running_misses = '0;

    // per-triangle tallies still owed by the core, kept in a ring, oldest first
    tri_out_t    tally_ring [TALLY_SLOTS];
    int unsigned tally_wr = 0;
    int unsigned tally_rd = 0;

    int  mismatch_count   = 0;
    int  triangles_sent   = 0;
    int  results_checked  = 0;
    int  restarts_sent    = 0;
    int  hits_seen        = 0;
    int  stall_cycles     = 0;
    int  longest_hold_off = 0;
    bit  idle_on          = 1'b1;
    bit  hold_off_req     = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // oldest slot holding v, or -1 when v is not cached
    function automatic int find_slot(input logic [VERTEX_W-1:0] v);
        for (int i = 0; i < held_entries; i++) begin
            if (cache_slots[i] == v) begin
                return i;
            end
        end
        return -1;
    endfunction

    // one ordered update: a hit swaps with the newest entry, a miss appends
    // and pushes out the oldest once the cache is full
    function automatic void touch_vertex(input logic [VERTEX_W-1:0] v);
        int                  slot;
        logic [VERTEX_W-1:0] swap;
        slot = find_slot(v);
        if (slot >= 0) begin
            swap                          = cache_slots[held_entries - 1];
            cache_slots[held_entries - 1] = cache_slots[slot];
            cache_slots[slot]             = swap;
        end else if (held_entries < CACHE_DEPTH_DEF) begin
            cache_slots[held_entries] = v;
            held_entries++;
        end else begin
            for (int i = 0; i < CACHE_DEPTH_DEF - 1; i++) begin
                cache_slots[i] = cache_slots[i + 1];
            end
            cache_slots[CACHE_DEPTH_DEF - 1] = v;
        end
    endfunction

    // hit/miss tally of one triangle, advancing the shadow cache and total
    function automatic tri_out_t tally_triangle(input tri_in_t t);
        tri_out_t            r;
        logic [VERTEX_W-1:0] corner [3];
        int unsigned         hits;
        int unsigned         misses;
        logic [TOTAL_W:0]    sum;
        corner[0] = t.vertex_a;
        corner[1] = t.vertex_b;
        corner[2] = t.vertex_c;
        hits      = 0;
        misses    = 0;
        if (t.restart) begin
            held_entries   = 0;
            running_misses = '0;
        end
        // all three lookups see the cache as it stood before the triangle
        for (int k = 0; k < 3; k++) begin
            if (find_slot(corner[k]) >= 0) begin
                hits++;
            end else begin
                misses++;
            end
        end
        // duplicates see whatever the earlier copies left behind
        for (int k = 0; k < 3; k++) begin
            touch_vertex(corner[k]);
        end
        sum = {1'b0, running_misses} + (TOTAL_W + 1)'(misses);
        running_misses = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
        r.hit_count  = COUNT_W'(hits);
        r.miss_count = COUNT_W'(misses);
        r.miss_total = running_misses;
        r.is_last    = t.last_triangle;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    function automatic tri_in_t make_triangle(input logic [VERTEX_W-1:0] a, b, c,
                                              input logic restart, last_triangle);
        tri_in_t t;
        t.vertex_a      = a;
        t.vertex_b      = b;
        t.vertex_c      = c;
        t.restart       = restart;
        t.last_triangle = last_triangle;
        return t;
    endfunction

    // offer one triangle, hold it until the transfer, then maybe go quiet;
    // valid stays high into the next call when no gap is drawn
    task automatic send_triangle(input tri_in_t t);
        s_valid   <= 1'b1;
        s_payload <= t;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        tally_ring[tally_wr % TALLY_SLOTS] = tally_triangle(t);
        tally_wr++;
        triangles_sent++;
        if (t.restart) begin
            restarts_sent++;
        end
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
    endtask

    // mesh-like stream: most triangles reuse indices near a slowly moving base
    // so hits, swaps and evictions all happen; a few are scattered noise
    task automatic run_random_triangles(input int count);
        tri_in_t             t;
        logic [VERTEX_W-1:0] base;
        base = VERTEX_W'($urandom);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 29) == 0) begin
                base = VERTEX_W'($urandom);
            end else if ($urandom_range(0, 3) == 0) begin
                base = base + VERTEX_W'($urandom_range(1, 4));
            end
            if ($urandom_range(0, 9) == 0) begin
                t.vertex_a = VERTEX_W'($urandom);
                t.vertex_b = VERTEX_W'($urandom);
                t.vertex_c = VERTEX_W'($urandom);
            end else begin
                t.vertex_a = base + VERTEX_W'($urandom_range(0, 11));
                t.vertex_b = base + VERTEX_W'($urandom_range(0, 11));
                t.vertex_c = base + VERTEX_W'($urandom_range(0, 11));
            end
            t.restart       = ($urandom_range(0, 39) == 0);
            t.last_triangle = ($urandom_range(0, 19) == 0);
            send_triangle(t);
        end
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // random stall bursts while idling is on, plus one long hold-off on request so the
    // core backs up into its input
    initial begin : receiver
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                for (int n = 0; n < HOLD_OFF_CYCLES; n++) begin
                    @(posedge aclk);
                    longest_hold_off = n + 1;
                end
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        // keep the log short if something goes badly wrong
        if (mismatch_count < 40) begin
            $display("%0t mismatch on %s: got %0d, want %0d", $time, field, got, want);
        end
        mismatch_count++;
    endtask

    // compare every result transfer with the oldest outstanding tally
    always @(posedge aclk) begin : result_check
        tri_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (tally_wr == tally_rd) begin
                report_mismatch("unexpected result", 32'(m_payload.miss_total), 32'd0);
            end else begin
                want = tally_ring[tally_rd % TALLY_SLOTS];
                tally_rd++;
                if (m_payload.hit_count !== want.hit_count) begin
                    report_mismatch("hit_count", 32'(m_payload.hit_count),
                                    32'(want.hit_count));
                end
                if (m_payload.miss_count !== want.miss_count) begin
                    report_mismatch("miss_count", 32'(m_payload.miss_count),
                                    32'(want.miss_count));
                end
                if (m_payload.miss_total !== want.miss_total) begin
                    report_mismatch("miss_total", m_payload.miss_total, want.miss_total);
                end
                if (m_payload.is_last !== want.is_last) begin
                    report_mismatch("is_last", 32'(m_payload.is_last), 32'(want.is_last));
                end
                hits_seen += m_payload.hit_count;
                results_checked++;
            end
        end
    end

    // hang detector: any transfer on either channel clears the count
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t no transfer for %0d cycles", $time, stall_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // first triangle after reset sees an empty cache and a zero total
    task automatic test_reset_state();
        send_triangle(make_triangle(16'd10, 16'd11, 16'd12, 1'b0, 1'b0));
        send_triangle(make_triangle(16'd12, 16'd10, 16'd11, 1'b0, 1'b0));
    endtask

    // lowest and highest indices, alternating bit patterns
    task automatic test_field_extremes();
        send_triangle(make_triangle(16'h0000, 16'hFFFF, 16'h8000, 1'b1, 1'b0));
        send_triangle(make_triangle(16'hFFFF, 16'h0000, 16'hFFFF, 1'b0, 1'b0));
        send_triangle(make_triangle(16'hAAAA, 16'h5555, 16'h0001, 1'b0, 1'b0));
    endtask

    // repeated indices in one triangle all count as the pre-triangle lookup says
    task automatic test_duplicates();
        send_triangle(make_triangle(16'd5, 16'd5, 16'd5, 1'b1, 1'b0));
        send_triangle(make_triangle(16'd5, 16'd6, 16'd5, 1'b0, 1'b0));
        send_triangle(make_triangle(16'd7, 16'd7, 16'd6, 1'b0, 1'b0));
    endtask

    // nine distinct indices overflow the cache; then hits reorder the entries
    task automatic test_eviction();
        send_triangle(make_triangle(16'd100, 16'd101, 16'd102, 1'b1, 1'b0));
        send_triangle(make_triangle(16'd103, 16'd104, 16'd105, 1'b0, 1'b0));
        send_triangle(make_triangle(16'd106, 16'd107, 16'd108, 1'b0, 1'b0));
        send_triangle(make_triangle(16'd100, 16'd108, 16'd101, 1'b0, 1'b0));
        send_triangle(make_triangle(16'd103, 16'd102, 16'd104, 1'b0, 1'b0));
    endtask

    // the last flag is only echoed, with and without a restart alongside
    task automatic test_last_flag();
        send_triangle(make_triangle(16'd1, 16'd2, 16'd3, 1'b0, 1'b1));
        send_triangle(make_triangle(16'd1, 16'd2, 16'd3, 1'b1, 1'b1));
    endtask

    // receiver stops for a long stretch while triangles keep coming, so the
    // core fills up and drops s_ready
    task automatic test_backpressure();
        hold_off_req = 1'b1;
        run_random_triangles(30);
    endtask

    task automatic test_random_with_idling();
        run_random_triangles(1080);
    endtask

    // final stretch at full rate on both sides
    task automatic test_random_full_rate();
        idle_on = 1'b0;
        run_random_triangles(220);
    endtask

    initial begin : main
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_field_extremes();
        test_duplicates();
        test_eviction();
        test_last_flag();
        test_backpressure();
        test_random_with_idling();
        test_random_full_rate();

        s_valid <= 1'b0;
        while (tally_wr != tally_rd) begin
            @(posedge aclk);
        end
        // anything still coming out now has no tally waiting for it
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d triangles (%0d with restart), checked %0d results, %0d cache hits",
                 triangles_sent, restarts_sent, results_checked, hits_seen);
        $display("receiver hold-off of %0d cycles, random idling on both sides, full-rate tail",
                 longest_hold_off);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/vcmc_pkg.sv
sv/vcmc_ctrl.sv
sv/vcmc_datapath.sv
sv/vertex_cache_miss_counter_core.sv
bench/tb.sv
